FILE: sv/pwbr_pkg.sv
// ----------------------------------------------------------------------------
// pwbr_pkg
// Shared types and constants for the pulse-width bit receiver.
// ----------------------------------------------------------------------------
package pwbr_pkg;

  // tick counter width, counters saturate at all ones
  localparam int unsigned COUNT_WIDTH = 16;
  // largest number of bits in one reply
  localparam int unsigned MAX_BITS    = 64;
  // width of the bit count register and bits-left counter
  localparam int unsigned BITS_W      = $clog2(MAX_BITS + 1);
  // width of the timeout registers and of the config data port
  localparam int unsigned TO_W        = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT        = 2'd2;

  // register reset values
  localparam logic [TO_W-1:0]   RESPONSE_TIMEOUT_RST = 16'd2304;
  localparam logic [TO_W-1:0]   HALF_BIT_TIMEOUT_RST = 16'd432;
  localparam logic [BITS_W-1:0] BIT_COUNT_RST        = BITS_W'(MAX_BITS);

  // first bit of a byte, MSB first
  localparam logic [7:0] BYTE_MSB = 8'h80;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_RESP_TO = 2'd2,
    KIND_BIT_TO  = 2'd3
  } kind_e;

endpackage

FILE: sv/pulse_width_bit_receiver.sv
// ----------------------------------------------------------------------------
// pulse_width_bit_receiver
// Single-wire pulse-width bit decoder with byte packing and timeouts.
// ----------------------------------------------------------------------------
// Takes one request per clock: either an arm command or one line sample. An
// arm starts a reception of bit_count bits (clamped to 1..64). The block then
// waits for the line to go low (response timeout), measures the low and high
// time of each bit (bit is 1 when high time is longer), fails on a phase that
// exceeds the half-bit timeout, emits each byte MSB first as it completes and
// reports done once the stop bit ends. Every request is decoded in the cycle
// it is taken and its result, if any, lands in the output register the next
// cycle; one request per cycle is sustained. The only stall is a result held
// in the output register while out_ready_i is low. Configuration writes take
// effect at once; bit_count is sampled at arm time.
// ----------------------------------------------------------------------------
module pulse_width_bit_receiver
  import pwbr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic                 line_level_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           rx_byte_o,
  output logic                 last_o,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TO_W-1:0]      cfg_data_i
);

  // phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WAIT = 3'd1;
  localparam logic [2:0] PH_LOW  = 3'd2;
  localparam logic [2:0] PH_HIGH = 3'd3;
  localparam logic [2:0] PH_STOP = 3'd4;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic [TO_W-1:0]        resp_to_q, half_to_q;
  logic [BITS_W-1:0]      bit_count_q;

  logic [2:0]             phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [COUNT_WIDTH-1:0] low_ticks_q, low_ticks_d;
  logic [7:0]             shift_q, shift_d;
  logic [2:0]             bib_q, bib_d;
  logic [BITS_W-1:0]      bits_left_q, bits_left_d;

  logic                   out_valid_q;
  kind_e                  kind_q;
  logic [7:0]             byte_q;
  logic                   last_q;

  logic                   res_valid;
  kind_e                  res_kind;
  logic [7:0]             res_byte;
  logic                   res_last;

  logic                   in_fire;
  logic [COUNT_WIDTH-1:0] limit;
  logic                   too_long;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [BITS_W-1:0]      arm_bits;
  logic [2:0]             bib_nxt;
  logic [BITS_W-1:0]      bl_nxt;
  logic [7:0]             shift_nxt;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_to_q   <= RESPONSE_TIMEOUT_RST;
      half_to_q   <= HALF_BIT_TIMEOUT_RST;
      bit_count_q <= BIT_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RESPONSE_TIMEOUT: resp_to_q   <= cfg_data_i;
        CFG_HALF_BIT_TIMEOUT: half_to_q   <= cfg_data_i;
        CFG_BIT_COUNT:        bit_count_q <= cfg_data_i[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // shared helpers: timeout compare, saturating count, clamped bit count
  assign limit    = (phase_q == PH_WAIT) ? COUNT_WIDTH'(resp_to_q)
                                         : COUNT_WIDTH'(half_to_q);
  assign too_long = tick_q >= limit;
  assign tick_inc = (tick_q == CNT_MAX) ? tick_q : tick_q + CNT_ONE;

  always_comb begin
    if (bit_count_q == '0) begin
      arm_bits = BITS_W'(1);
    end else if (bit_count_q > BITS_W'(MAX_BITS)) begin
      arm_bits = BITS_W'(MAX_BITS);
    end else begin
      arm_bits = bit_count_q;
    end
  end

  // bit completion on the falling edge ending a high phase
  assign bib_nxt   = bib_q + 3'd1;
  assign bl_nxt    = (bits_left_q != '0) ? bits_left_q - BITS_W'(1) : '0;
  assign shift_nxt = (tick_q > low_ticks_q) ? (shift_q | (BYTE_MSB >> bib_q)) : shift_q;

  // decode of one request
  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    low_ticks_d = low_ticks_q;
    shift_d     = shift_q;
    bib_d       = bib_q;
    bits_left_d = bits_left_q;
    res_valid   = 1'b0;
    res_kind    = KIND_DATA;
    res_byte    = '0;
    res_last    = 1'b0;

    if (cmd_i) begin
      phase_d     = PH_WAIT;
      tick_d      = '0;
      low_ticks_d = '0;
      shift_d     = '0;
      bib_d       = '0;
      bits_left_d = arm_bits;
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_WAIT: begin
          if (line_level_i) begin
            if (too_long) begin
              phase_d   = PH_IDLE;
              res_valid = 1'b1;
              res_kind  = KIND_RESP_TO;
              res_last  = 1'b1;
            end else begin
              tick_d = tick_inc;
            end
          end else begin
            phase_d = PH_LOW;
            tick_d  = CNT_ONE;
          end
        end
        PH_LOW: begin
          if (!line_level_i) begin
            if (too_long) begin
              phase_d   = PH_IDLE;
              res_valid = 1'b1;
              res_kind  = KIND_BIT_TO;
              res_last  = 1'b1;
            end else begin
              tick_d = tick_inc;
            end
          end else begin
            low_ticks_d = tick_q;
            phase_d     = PH_HIGH;
            tick_d      = CNT_ONE;
          end
        end
        PH_HIGH: begin
          if (line_level_i) begin
            if (too_long) begin
              phase_d   = PH_IDLE;
              res_valid = 1'b1;
              res_kind  = KIND_BIT_TO;
              res_last  = 1'b1;
            end else begin
              tick_d = tick_inc;
            end
          end else begin
            bits_left_d = bl_nxt;
            if (bib_nxt == 3'd0 || bl_nxt == '0) begin
              res_valid = 1'b1;
              res_kind  = KIND_DATA;
              res_byte  = shift_nxt;
              shift_d   = '0;
              bib_d     = '0;
            end else begin
              shift_d = shift_nxt;
              bib_d   = bib_nxt;
            end
            phase_d = (bl_nxt == '0) ? PH_STOP : PH_LOW;
            tick_d  = CNT_ONE;
          end
        end
        PH_STOP: begin
          if (!line_level_i) begin
            if (too_long) begin
              phase_d   = PH_IDLE;
              res_valid = 1'b1;
              res_kind  = KIND_BIT_TO;
              res_last  = 1'b1;
            end else begin
              tick_d = tick_inc;
            end
          end else begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res_kind  = KIND_DONE;
            res_last  = 1'b1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      low_ticks_q <= '0;
      shift_q     <= '0;
      bib_q       <= '0;
      bits_left_q <= '0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      low_ticks_q <= low_ticks_d;
      shift_q     <= shift_d;
      bib_q       <= bib_d;
      bits_left_q <= bits_left_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q <= res_kind;
      byte_q <= res_byte;
      last_q <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign rx_byte_o   = byte_q;
  assign last_o      = last_q;

endmodule

FILE: test/tb_pulse_width_bit_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pulse_width_bit_receiver
// Self-checking bench for the pulse-width bit receiver: a cycle-level decoder
// model in a small scoreboard class predicts every byte, done and timeout
// result from the accepted requests and the register settings, while plain
// tasks play armed replies with random bit timing, injected phase overruns,
// abandoned receptions and line noise under random request and result stalls.
// ----------------------------------------------------------------------------
import pwbr_pkg::*;

// decoder phases of the bench's own model
typedef enum logic [2:0] {
  RX_IDLE,
  RX_WAIT,
  RX_LOW,
  RX_HIGH,
  RX_STOP
} rx_phase_e;

typedef struct packed {
  kind_e      kind;
  logic [7:0] data;
  logic       last;
} rx_result_t;

// decoder model plus the queue of results it still owes
class reply_tracker;
  rx_result_t               due_results[$];
  logic [TO_W-1:0]          resp_limit;
  logic [TO_W-1:0]          half_limit;
  logic [BITS_W-1:0]        bits_cfg;
  rx_phase_e                phase;
  logic [COUNT_WIDTH-1:0]   ticks;
  logic [COUNT_WIDTH-1:0]   low_len;
  logic [7:0]               shift;
  logic [2:0]               bit_pos;
  logic [BITS_W-1:0]        remaining;
  int unsigned              mismatches;
  int unsigned              writes;
  int unsigned              kind_seen[4];

  function new();
    resp_limit = RESPONSE_TIMEOUT_RST;
    half_limit = HALF_BIT_TIMEOUT_RST;
    bits_cfg   = BIT_COUNT_RST;
    phase      = RX_IDLE;
    ticks      = '0;
    low_len    = '0;
    shift      = '0;
    bit_pos    = '0;
    remaining  = '0;
    mismatches = 0;
    writes     = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TO_W-1:0] val);
    writes++;
    case (idx)
      CFG_RESPONSE_TIMEOUT: resp_limit = val;
      CFG_HALF_BIT_TIMEOUT: half_limit = val;
      CFG_BIT_COUNT:        bits_cfg   = val[BITS_W-1:0];
      default: ;
    endcase
  endfunction

  // bit count as taken at arm time
  function int unsigned armed_bits();
    if (bits_cfg == 0) return 1;
    if (bits_cfg > MAX_BITS) return MAX_BITS;
    return bits_cfg;
  endfunction

  function int unsigned pending();
    return due_results.size();
  endfunction

  // a tick that continues the phase: fail once the limit is reached
  function bit run_too_long(logic [TO_W-1:0] limit);
    if (ticks >= limit) return 1'b1;
    if (ticks != '1) ticks = ticks + 1'b1;
    return 1'b0;
  endfunction

  function void queue_result(kind_e k, logic [7:0] d, logic l);
    rx_result_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    due_results.push_back(r);
  endfunction

  function void fail_phase(kind_e k);
    phase = RX_IDLE;
    queue_result(k, 8'h00, 1'b1);
  endfunction

  function void take_request(logic arm, logic level);
    if (arm) begin
      phase     = RX_WAIT;
      ticks     = '0;
      low_len   = '0;
      shift     = '0;
      bit_pos   = '0;
      remaining = BITS_W'(armed_bits());
      return;
    end
    case (phase)
      RX_WAIT: begin
        if (level) begin
          if (run_too_long(resp_limit)) fail_phase(KIND_RESP_TO);
        end else begin
          phase = RX_LOW;
          ticks = COUNT_WIDTH'(1);
        end
      end
      RX_LOW: begin
        if (!level) begin
          if (run_too_long(half_limit)) fail_phase(KIND_BIT_TO);
        end else begin
          low_len = ticks;
          phase   = RX_HIGH;
          ticks   = COUNT_WIDTH'(1);
        end
      end
      RX_HIGH: begin
        if (level) begin
          if (run_too_long(half_limit)) fail_phase(KIND_BIT_TO);
        end else begin
          // falling edge closes the bit: one when high outlasted low
          if (ticks > low_len) shift = shift | (BYTE_MSB >> bit_pos);
          bit_pos = bit_pos + 3'd1;
          if (remaining != 0) remaining = remaining - 1'b1;
          if (bit_pos == 0 || remaining == 0) begin
            queue_result(KIND_DATA, shift, 1'b0);
            shift   = '0;
            bit_pos = '0;
          end
          phase = (remaining == 0) ? RX_STOP : RX_LOW;
          ticks = COUNT_WIDTH'(1);
        end
      end
      RX_STOP: begin
        if (!level) begin
          if (run_too_long(half_limit)) fail_phase(KIND_BIT_TO);
        end else begin
          phase = RX_IDLE;
          queue_result(KIND_DONE, 8'h00, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task match_result(logic [1:0] kind, logic [7:0] data, logic last);
    rx_result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result kind %0d with nothing due", kind));
      return;
    end
    want = due_results.pop_front();
    kind_seen[int'(want.kind)]++;
    if (kind !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
    if (data !== want.data)
      report_mismatch($sformatf("rx_byte %02h, expected %02h", data, want.data));
    if (last !== want.last)
      report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
  endtask
endclass

module tb_pulse_width_bit_receiver;

  localparam int unsigned ITEM_TARGET = 1700;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 4000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 cmd_i;
  logic                 line_level_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [1:0]           kind_o;
  logic [7:0]           rx_byte_o;
  logic                 last_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [TO_W-1:0]      cfg_data_i;

  reply_tracker board;
  int unsigned  req_count;
  int unsigned  burst_left;
  int unsigned  settings_run;
  int unsigned  quiet;
  bit           sender_steady;
  bit           hold_off_req;

  pulse_width_bit_receiver DUT (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // model update and result check on every handshake
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.take_request(cmd_i, line_level_i);
    if (rst_ni && out_valid_o && out_ready_i) board.match_result(kind_o, rx_byte_o, last_o);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side: stall pattern in segments, plus one long hold-off on demand
  initial begin : result_sink
    int unsigned seg_left;
    int unsigned mode;
    seg_left = 0;
    mode     = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // one request, with bursts and random gaps unless the sender runs steady
  task automatic send_req(input logic arm, input logic level);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    cmd_i        <= arm;
    line_level_i <= level;
    do @(posedge clk_i); while (!in_ready_o);
    req_count++;
  endtask

  task automatic hold_line(input logic level, input int unsigned n);
    repeat (n) send_req(1'b0, level);
  endtask

  // wait until every owed result is in, then let the block settle
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [TO_W-1:0] resp, input logic [TO_W-1:0] half,
                              input logic [TO_W-1:0] bits_word);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [TO_W-1:0]      vals[3];
    idx  = '{CFG_RESPONSE_TIMEOUT, CFG_HALF_BIT_TIMEOUT, CFG_BIT_COUNT};
    vals = '{resp, half, bits_word};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      board.set_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // phase length that stays within the limit, now and then right on it
  function automatic int unsigned phase_len(input int unsigned limit,
                                            input int unsigned min_len);
    int unsigned cap;
    cap = (limit < 6) ? limit : 6;
    if (cap < min_len) cap = min_len;
    if (limit <= 40 && limit >= min_len && $urandom_range(0, 7) == 0) return limit;
    return $urandom_range(min_len, cap);
  endfunction

  function automatic logic [TO_W-1:0] pick_timeout();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TO_W'(1);
      2: return '1;
      3: return TO_W'($urandom);
      default: return TO_W'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [TO_W-1:0] pick_bits();
    logic [TO_W-1:0] v;
    case ($urandom_range(0, 11))
      0: v = '0;
      1: v = TO_W'(1);
      2: v = TO_W'(MAX_BITS);
      3: v = TO_W'(127);
      4: v = TO_W'($urandom_range(MAX_BITS + 1, 127));
      default: v = TO_W'($urandom_range(2, 17));
    endcase
    // bits above the register width are dropped
    if ($urandom_range(0, 5) == 0) v = v | (TO_W'($urandom) & 16'hFF80);
    return v;
  endfunction

  // one armed reply; a phase may be stretched past its limit to force a timeout
  task automatic run_reply(input int unsigned fault_pct);
    int unsigned nbits;
    int unsigned cut;
    logic        level;
    nbits = board.armed_bits();
    cut   = ($urandom_range(0, 99) < fault_pct) ? $urandom_range(0, 2 * nbits + 1)
                                                : 2 * nbits + 2;
    send_req(1'b1, 1'($urandom_range(0, 1)));
    if (cut == 0 && board.resp_limit <= 40) begin
      hold_line(1'b1, board.resp_limit + 1);
      return;
    end
    hold_line(1'b1, phase_len(board.resp_limit, 0));
    // odd slots low, even slots high, the last slot is the stop bit
    for (int unsigned slot = 1; slot <= 2 * nbits + 1; slot++) begin
      level = (slot % 2 == 0);
      if (slot == cut && board.half_limit <= 40) begin
        hold_line(level, board.half_limit + 1);
        return;
      end
      hold_line(level, phase_len(board.half_limit, 1));
    end
    send_req(1'b0, 1'b1);
  endtask

  task automatic directed_cases();
    // idle ticks do nothing
    send_req(1'b0, 1'b0);
    send_req(1'b0, 1'b1);
    // zero timeouts, zero bit count taken as one
    wait_results_done();
    write_config('0, '0, '0);
    send_req(1'b1, 1'b0);
    send_req(1'b0, 1'b1);
    send_req(1'b1, 1'b1);
    hold_line(1'b0, 2);
    send_req(1'b1, 1'b0);
    send_req(1'b0, 1'b0);
    hold_line(1'b1, 2);
    // stop bit overrun after an equal-length zero bit
    send_req(1'b1, 1'b0);
    send_req(1'b0, 1'b0);
    send_req(1'b0, 1'b1);
    hold_line(1'b0, 2);
    // a high phase overrun, then a re-arm that abandons a reception and a zero bit
    wait_results_done();
    write_config(TO_W'(1), TO_W'(1), TO_W'(1));
    send_req(1'b1, 1'b1);
    send_req(1'b0, 1'b1);
    send_req(1'b0, 1'b0);
    hold_line(1'b1, 2);
    send_req(1'b0, 1'b0);
    send_req(1'b0, 1'b1);
    send_req(1'b1, 1'b0);
    send_req(1'b0, 1'b0);
    send_req(1'b1, 1'b1);
    send_req(1'b0, 1'b0);
    send_req(1'b0, 1'b1);
    send_req(1'b0, 1'b0);
    send_req(1'b0, 1'b1);
  endtask

  initial begin
    int unsigned n_rep;
    board         = new();
    req_count     = 0;
    burst_left    = 0;
    settings_run  = 0;
    sender_steady = 1'b0;
    hold_off_req  = 1'b0;
    in_valid_i   <= 1'b0;
    cmd_i        <= 1'b0;
    line_level_i <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_RESPONSE_TIMEOUT;
    cfg_data_i   <= '0;
    rst_ni       <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full reply on the reset settings
    run_reply(0);
    directed_cases();

    // largest timeouts and an oversized bit count: one 64 bit reply
    wait_results_done();
    write_config('1, '1, TO_W'(127));
    sender_steady = 1'b1;
    run_reply(0);

    // long result hold-off while short replies keep coming
    wait_results_done();
    write_config(TO_W'(20), TO_W'(10), TO_W'(8));
    hold_off_req = 1'b1;
    repeat (6) run_reply(0);
    sender_steady = 1'b0;

    // random settings, replies, abandoned receptions and noise
    while (req_count < ITEM_TARGET) begin
      wait_results_done();
      write_config(pick_timeout(), pick_timeout(), pick_bits());
      sender_steady = ($urandom_range(0, 3) == 0);
      n_rep = (board.armed_bits() > 16) ? $urandom_range(1, 2) : $urandom_range(2, 6);
      repeat (n_rep) begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 8))
              send_req($urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
          end
          1: begin
            send_req(1'b1, 1'($urandom_range(0, 1)));
            hold_line(1'b1, $urandom_range(0, 2));
            hold_line(1'b0, $urandom_range(1, 2));
            run_reply(25);
          end
          default: run_reply(25);
        endcase
      end
    end

    wait_results_done();
    repeat (8) @(posedge clk_i);
    $display("covered %0d requests over %0d settings: %0d bytes, %0d done, %0d register writes",
             req_count, settings_run, board.kind_seen[KIND_DATA], board.kind_seen[KIND_DONE],
             board.writes);
    $display("failures seen: %0d response timeouts, %0d bit timeouts; %0d mismatches",
             board.kind_seen[KIND_RESP_TO], board.kind_seen[KIND_BIT_TO], board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
